### src/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared widths, codes and constants of the depth colormap / rotate block.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ROTATION     = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } t_rot;

    typedef enum logic [2:0] {
        SEG_BLACK,
        SEG_RED_FALL,
        SEG_GREEN_RISE,
        SEG_BLUE_FALL,
        SEG_RED_RISE,
        SEG_GREEN_FALL,
        SEG_SAT
    } t_seg;

    // segment boundaries
    localparam logic [DEPTH_W-1:0] D_NEAR   = 16'h0190;
    localparam logic [DEPTH_W-1:0] D_BLUE   = 16'h0400;
    localparam logic [DEPTH_W-1:0] D_CYAN   = 16'h0600;
    localparam logic [DEPTH_W-1:0] D_GREEN  = 16'h0800;
    localparam logic [DEPTH_W-1:0] D_YELLOW = 16'h0C00;
    localparam logic [DEPTH_W-1:0] D_FAR    = 16'h1000;

    localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] COLOR_SAT   = 32'hFFFF_0000;
    localparam logic [7:0]         CH_MAX      = 8'hFF;
    localparam logic [7:0]         CH_ZERO     = 8'h00;

    // floor(n / 39) == (n * RECIP_39) >> RECIP_SHIFT for n < 18724
    localparam logic [12:0] RECIP_39    = 13'd6722;
    localparam int          RECIP_SHIFT = 18;

endpackage

### src/dcr_in_if.sv
// ----------------------------------------------------------------------------
// dcr_in_if
// Depth sample stream channel.
// ----------------------------------------------------------------------------
interface dcr_in_if;
    logic                         valid;
    logic                         ready;
    logic [dcr_pkg::DEPTH_W-1:0]  depth_sample;

    modport source (output valid, output depth_sample, input ready);
    modport sink   (input valid, input depth_sample, output ready);
endinterface

### src/dcr_out_if.sv
// ----------------------------------------------------------------------------
// dcr_out_if
// Colored pixel result channel.
// ----------------------------------------------------------------------------
interface dcr_out_if;
    logic                         valid;
    logic                         ready;
    logic [dcr_pkg::COLOR_W-1:0]  pixel_color;
    logic [dcr_pkg::ADDR_W-1:0]   pixel_address;
    logic                         frame_end;

    modport source (output valid, output pixel_color, output pixel_address,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_color, input pixel_address,
                    input frame_end, output ready);
endinterface

### src/dcr_cfg_if.sv
// ----------------------------------------------------------------------------
// dcr_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface dcr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dcr_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [dcr_pkg::CFG_DATA_W-1:0] reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

### src/dcr_state_ram.sv
// ----------------------------------------------------------------------------
// dcr_state_ram
// Single-entry position state store, registered read.
// ----------------------------------------------------------------------------
module dcr_state_ram #(
    parameter int DATA_W = 20
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [0:0];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[0] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[0];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dcr_colormap.sv
// ----------------------------------------------------------------------------
// dcr_colormap
// Two-stage piecewise linear depth to ARGB map.
// ----------------------------------------------------------------------------
module dcr_colormap (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dcr_pkg::DEPTH_W-1:0] i_depth,
    output logic [dcr_pkg::COLOR_W-1:0] o_color
);
    import dcr_pkg::*;

    t_seg        n_seg, r_seg;
    logic [9:0]  n_ofs;
    logic [17:0] n_prod, r_prod;
    logic [26:0] recip_prod;
    logic [7:0]  q_624, q_512, q_1024;

    // stage 1: segment select and 255 * offset
    always_comb begin
        n_seg = SEG_BLACK;
        n_ofs = '0;
        if (i_depth < D_NEAR) begin
            n_seg = SEG_BLACK;
        end else if (i_depth >= D_FAR) begin
            n_seg = SEG_SAT;
        end else if (i_depth < D_BLUE) begin
            n_seg = SEG_RED_FALL;
            n_ofs = 10'(i_depth - D_NEAR);
        end else if (i_depth < D_CYAN) begin
            n_seg = SEG_GREEN_RISE;
            n_ofs = 10'(i_depth - D_BLUE);
        end else if (i_depth < D_GREEN) begin
            n_seg = SEG_BLUE_FALL;
            n_ofs = 10'(i_depth - D_CYAN);
        end else if (i_depth < D_YELLOW) begin
            n_seg = SEG_RED_RISE;
            n_ofs = 10'(i_depth - D_GREEN);
        end else begin
            n_seg = SEG_GREEN_FALL;
            n_ofs = 10'(i_depth - D_YELLOW);
        end
        n_prod = 18'(n_ofs) * 18'(CH_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg  <= n_seg;
            r_prod <= n_prod;
        end
    end

    // stage 2: divide by 624 (= 16 * 39), 512 or 1024
    assign recip_prod = 27'(r_prod[17:4]) * 27'(RECIP_39);
    assign q_624      = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign q_512      = r_prod[16:9];
    assign q_1024     = r_prod[17:10];

    always_comb begin
        case (r_seg)
            SEG_BLACK:      o_color = COLOR_BLACK;
            SEG_SAT:        o_color = COLOR_SAT;
            SEG_RED_FALL:   o_color = {CH_MAX, CH_MAX - q_624, CH_ZERO, CH_MAX};
            SEG_GREEN_RISE: o_color = {CH_MAX, CH_ZERO, q_512, CH_MAX};
            SEG_BLUE_FALL:  o_color = {CH_MAX, CH_ZERO, CH_MAX, CH_MAX - q_512};
            SEG_RED_RISE:   o_color = {CH_MAX, q_1024, CH_MAX, CH_ZERO};
            SEG_GREEN_FALL: o_color = {CH_MAX, CH_MAX, CH_MAX - q_1024, CH_ZERO};
            default:        o_color = COLOR_BLACK;
        endcase
    end

endmodule

### src/dcr_pos.sv
// ----------------------------------------------------------------------------
// dcr_pos
// Position update and rotated address, two stages.
// ----------------------------------------------------------------------------
module dcr_pos #(
    parameter int CW = 10,
    parameter int DW = 11
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [CW-1:0]              i_x,
    input  logic [CW-1:0]              i_y,
    input  logic [DW-1:0]              i_w,
    input  logic [DW-1:0]              i_h,
    input  logic [1:0]                 i_mode,
    output logic [CW-1:0]              o_next_x,
    output logic [CW-1:0]              o_next_y,
    output logic [dcr_pkg::ADDR_W-1:0] o_addr,
    output logic                       o_last
);
    import dcr_pkg::*;

    localparam int PW = (CW + DW + 1 > ADDR_W) ? CW + DW + 1 : ADDR_W;

    logic [CW-1:0] xe, ye;
    logic [DW-1:0] x1, y1;
    logic          col_wrap, row_wrap;
    logic [CW-1:0] n_a, n_c, r_a, r_c;
    logic [DW-1:0] n_b, r_b;
    logic          n_last, r_last;
    logic [PW-1:0] sum;

    always_comb begin
        xe = (DW'(i_x) >= i_w) ? CW'(i_w - 1'b1) : i_x;
        ye = (DW'(i_y) >= i_h) ? CW'(i_h - 1'b1) : i_y;
        x1 = DW'(xe) + 1'b1;
        y1 = DW'(ye) + 1'b1;
        col_wrap = (x1 >= i_w);
        row_wrap = (y1 >= i_h);

        o_next_x = col_wrap ? '0 : CW'(x1);
        o_next_y = col_wrap ? (row_wrap ? '0 : CW'(y1)) : ye;
        n_last   = col_wrap && row_wrap;

        case (i_mode)
            ROT_CW: begin
                n_a = xe;
                n_b = i_h;
                n_c = CW'(i_h - 1'b1 - DW'(ye));
            end
            ROT_CCW: begin
                n_a = CW'(i_w - 1'b1 - DW'(xe));
                n_b = i_h;
                n_c = ye;
            end
            default: begin
                n_a = ye;
                n_b = i_w;
                n_c = xe;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
            r_last <= n_last;
        end
    end

    assign sum    = PW'(r_a) * PW'(r_b) + PW'(r_c);
    assign o_addr = sum[ADDR_W-1:0];
    assign o_last = r_last;

endmodule

### src/depth_colormap_rotate_core.sv
// ----------------------------------------------------------------------------
// depth_colormap_rotate_core
// Depth sample stream to ARGB pixels with rotated output addresses.
// ----------------------------------------------------------------------------
// Takes one depth sample per clock and returns one pixel per sample through
// the input, second-stage and output registers; the whole pipeline holds while
// the output register is full and not taken. The rate is set by the frame
// position read-modify-write: the position lives in a single-entry store with
// a registered read, and a bypass hands the value written by the previous
// sample straight to the next. A valid flag stands in for clearing the store
// after reset or a register write, so no clearing pass is needed. The address
// multiply and the colormap reciprocal multiply each sit in the second stage.
module depth_colormap_rotate_core #(
    parameter int MAX_DIM = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcr_in_if.sink    i_in,
    dcr_cfg_if.sink   i_cfg,
    dcr_out_if.source o_out
);
    import dcr_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    logic            adv, in_xfer, cfg_xfer, s1_wr;
    logic [DW-1:0]   r_w, r_h;
    logic [1:0]      r_mode;
    logic            r_clr;
    logic            r_s1_valid, r_s2_valid, r_out_valid;
    logic [DEPTH_W-1:0] r_s1_depth;
    logic            r_byp;
    logic [2*CW-1:0] r_byp_data;
    logic [2*CW-1:0] rd_data, pos, wr_data;
    logic [CW-1:0]   next_x, next_y;
    logic [ADDR_W-1:0]  addr;
    logic            last;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] r_out_color;
    logic [ADDR_W-1:0]  r_out_addr;
    logic            r_out_last;

    assign adv      = !r_out_valid || o_out.ready;
    assign in_xfer  = i_in.valid && adv;
    assign cfg_xfer = i_cfg.valid;
    assign s1_wr    = r_s1_valid && adv;

    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    // configuration; any write to the width, height or rotation register restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= eff_dim(FRAME_WIDTH_RST);
            r_h    <= eff_dim(FRAME_HEIGHT_RST);
            r_mode <= ROT_NONE;
            r_clr  <= 1'b1;
        end else begin
            if (cfg_xfer) begin
                unique case (i_cfg.reg_index)
                    REG_FRAME_WIDTH: begin
                        r_w   <= eff_dim(i_cfg.reg_data);
                        r_clr <= 1'b1;
                    end
                    REG_FRAME_HEIGHT: begin
                        r_h   <= eff_dim(i_cfg.reg_data);
                        r_clr <= 1'b1;
                    end
                    REG_ROTATION: begin
                        r_mode <= i_cfg.reg_data[1:0];
                        r_clr  <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (s1_wr) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign wr_data = {next_y, next_x};

    dcr_state_ram #(
        .DATA_W (2*CW)
    ) u_state (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_wdata (wr_data),
        .i_re    (in_xfer),
        .o_rdata (rd_data)
    );

    // bypass when the read meets a write or a cleared store
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_depth <= i_in.depth_sample;
            r_byp      <= s1_wr || r_clr;
            r_byp_data <= s1_wr ? wr_data : '0;
        end
    end

    assign pos = r_byp ? r_byp_data : rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= in_xfer;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    dcr_pos #(
        .CW (CW),
        .DW (DW)
    ) u_pos (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_x      (pos[CW-1:0]),
        .i_y      (pos[2*CW-1:CW]),
        .i_w      (r_w),
        .i_h      (r_h),
        .i_mode   (r_mode),
        .o_next_x (next_x),
        .o_next_y (next_y),
        .o_addr   (addr),
        .o_last   (last)
    );

    dcr_colormap u_cmap (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_depth (r_s1_depth),
        .o_color (color)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_color <= color;
            r_out_addr  <= addr;
            r_out_last  <= last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pixel_color   = r_out_color;
    assign o_out.pixel_address = r_out_addr;
    assign o_out.frame_end     = r_out_last;

endmodule

### src/dcr_checker.sv
// ----------------------------------------------------------------------------
// dcr_checker
// Port-level checks of the depth colormap / rotate core.
// ----------------------------------------------------------------------------
module dcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dcr_pkg::COLOR_W-1:0] i_out_color,
    input logic [dcr_pkg::ADDR_W-1:0]  i_out_addr,
    input logic                        i_out_last
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_color[31:24] == 8'hFF)
        else $error("alpha not opaque");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_color)
            && $stable(i_out_addr) && $stable(i_out_last))
        else $error("stalled output changed");

endmodule

bind depth_colormap_rotate_core dcr_checker u_dcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_color (o_out.pixel_color),
    .i_out_addr  (o_out.pixel_address),
    .i_out_last  (o_out.frame_end)
);
